// ===== design/svpwm_pkg.sv =====
// ---------------------------------------------------------------------------
// SVPWM duty generator package
// Shared constants, arctangent table and pipeline word types.
// ---------------------------------------------------------------------------
package svpwm_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int DUTY_FRAC_BITS_DEF = 16;
  localparam int ROT_STEPS          = 24;
  localparam int CMD_W              = 16;
  localparam int ACC_W              = 36;
  localparam int CMD_LIMIT          = 16384;
  localparam int STAGES_PER_REG     = 4;

  localparam logic [29:0] INVGAIN_Q30 = 30'd652032874;
  localparam logic [30:0] ROOT3_Q30   = 31'd1859775393;

  // Arctangent of 2^-i in 2^32-per-turn units.
  function automatic logic [31:0] turn_atan(input logic [4:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // Rotator state carried between CORDIC stages.
  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [32:0]      z;
  } svpwm_rot_t;

endpackage

// ===== design/svpwm_cordic.sv =====
// ---------------------------------------------------------------------------
// SVPWM CORDIC rotator
// Quarter-turn fold plus 24 rotation steps, a register every four steps.
// ---------------------------------------------------------------------------
module svpwm_cordic #(
  parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [ANGLE_BITS-1:0]            angle,
  input  logic signed [svpwm_pkg::CMD_W-1:0] volt_d,
  input  logic signed [svpwm_pkg::CMD_W-1:0] volt_q,
  output logic                             out_vld,
  output logic signed [svpwm_pkg::ACC_W-1:0] x_out,
  output logic signed [svpwm_pkg::ACC_W-1:0] y_out
);
  import svpwm_pkg::*;

  localparam int NREG = ROT_STEPS / STAGES_PER_REG;

  svpwm_rot_t rot_r [NREG+1];
  logic       vld_r [NREG+1];
  svpwm_rot_t rot_nxt [NREG+1];

  // Clamp, fold by quarter turn, form residue.
  logic signed [CMD_W-1:0] d_c, q_c;
  logic [31:0]             ph, resid;
  logic [1:0]              quad;
  logic signed [ACC_W-1:0] x0, y0;

  function automatic logic signed [CMD_W-1:0] clampv(input logic signed [CMD_W-1:0] s);
    logic signed [CMD_W-1:0] r;
    begin
      if (s > CMD_W'(CMD_LIMIT)) r = CMD_W'(CMD_LIMIT);
      else if (s < -CMD_W'(CMD_LIMIT)) r = -CMD_W'(CMD_LIMIT);
      else r = s;
      return r;
    end
  endfunction

  always_comb begin
    d_c   = clampv(volt_d);
    q_c   = clampv(volt_q);
    ph    = {angle, {(32-ANGLE_BITS){1'b0}}};
    quad  = 2'((ph + 32'h2000_0000) >> 30);
    resid = ph - {quad, 30'd0};
    x0    = ACC_W'(d_c) <<< 16;
    y0    = ACC_W'(q_c) <<< 16;
    rot_nxt[0].z = {resid[31], resid};
    case (quad)
      2'd1: begin rot_nxt[0].x = -y0; rot_nxt[0].y = x0;  end
      2'd2: begin rot_nxt[0].x = -x0; rot_nxt[0].y = -y0; end
      2'd3: begin rot_nxt[0].x = y0;  rot_nxt[0].y = -x0; end
      default: begin rot_nxt[0].x = x0; rot_nxt[0].y = y0; end
    endcase
  end

  // Four rotation steps between each pair of registers.
  for (genvar g = 0; g < NREG; g++) begin : g_stage
    always_comb begin
      svpwm_rot_t s;
      s = rot_r[g];
      for (int k = 0; k < STAGES_PER_REG; k++) begin
        logic signed [ACC_W-1:0] dx, dy;
        logic [4:0] i;
        i  = 5'(g*STAGES_PER_REG + k);
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (!s.z[32]) begin
          s.x = s.x - dx; s.y = s.y + dy; s.z = s.z - $signed({1'b0, turn_atan(i)});
        end else begin
          s.x = s.x + dx; s.y = s.y - dy; s.z = s.z + $signed({1'b0, turn_atan(i)});
        end
      end
      rot_nxt[g+1] = s;
    end
  end

  // Stage registers.
  for (genvar g = 0; g <= NREG; g++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= (g == 0) ? in_vld : vld_r[(g == 0) ? 0 : g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rot_r[g] <= rot_nxt[g];
      end
    end
  end

  assign out_vld = vld_r[NREG];
  assign x_out   = rot_r[NREG].x;
  assign y_out   = rot_r[NREG].y;

endmodule

// ===== design/svpwm_duty_generator_top.sv =====
// ---------------------------------------------------------------------------
// SVPWM duty generator top
// Inverse Park by CORDIC, sector search, dwell times and phase duties.
// ---------------------------------------------------------------------------
// The path from input word accept to output word valid holds 13 register stages.
// One word per cycle unless the output stalls; the CORDIC pipeline holds seven registers.
// All stages advance together; a stall on the output holds every stage.
// Reset clears valid bits only; no clearing pass, no state across words.
module svpwm_duty_generator_top #(
  parameter int ANGLE_BITS     = svpwm_pkg::ANGLE_BITS_DEF,
  parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // angle, volt_d, volt_q from bit 0 up
  input  logic [((ANGLE_BITS+32+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // duty_u, duty_v, duty_w, sector, overmodulated from bit 0 up
  output logic [((3*(DUTY_FRAC_BITS+2)+4+7)/8)*8-1:0] out_tdata
);
  import svpwm_pkg::*;

  localparam int DW  = DUTY_FRAC_BITS + 2;
  localparam int OW  = ((3*DW+4+7)/8)*8;
  localparam int NV  = 6;

  logic en;
  logic cvld;
  logic signed [ACC_W-1:0] cx, cy;

  // Whole pipe advances unless the output is full and stalled.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  svpwm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid),
    .angle(in_tdata[ANGLE_BITS-1:0]),
    .volt_d(in_tdata[ANGLE_BITS +: 16]),
    .volt_q(in_tdata[ANGLE_BITS+16 +: 16]),
    .out_vld(cvld), .x_out(cx), .y_out(cy)
  );

  logic vld_r [NV];

  // Stage A: inverse gain products.
  logic signed [66:0] ax_r, ay_r;
  // Stage B: alpha, beta.
  logic signed [ACC_W-1:0] al_r, be_r;
  // Stage C: sqrt(3)*beta.
  logic signed [67:0] sbp_r;
  logic signed [ACC_W-1:0] al2_r, be2_r;
  // Stage D: sector, T1, T2.
  logic [2:0] sec_r, sec_nxt;
  logic signed [ACC_W+2:0] t1_r, t2_r, t1_nxt, t2_nxt;
  // Stage E: T0 half and flag.
  logic signed [ACC_W+3:0] half_r, half_nxt;
  logic signed [ACC_W+2:0] t1e_r, t2e_r;
  logic [2:0] sece_r;
  logic ovm_r, ovm_nxt;
  // Stage F: output word.
  logic [OW-1:0] out_r, out_nxt;

  logic signed [ACC_W+2:0] sb, u, v, vx, vy, vz;

  always_comb begin
    sb = (ACC_W+3)'(sbp_r >>> 30);
    u  = sb - 3*(ACC_W+3)'(al2_r);
    v  = sb + 3*(ACC_W+3)'(al2_r);
    vx = sb;
    vy = v >>> 1;
    vz = u >>> 1;
    if (al2_r == '0 && be2_r == '0) sec_nxt = 3'd0;
    else if (be2_r > 0 || (be2_r == '0 && al2_r >= 0))
      sec_nxt = (u < 0) ? 3'd0 : ((v > 0) ? 3'd1 : 3'd2);
    else
      sec_nxt = (u > 0) ? 3'd3 : ((v < 0) ? 3'd4 : 3'd5);
    case (sec_nxt)
      3'd0: begin t1_nxt = -vz; t2_nxt = vx;  end
      3'd1: begin t1_nxt = vy;  t2_nxt = vz;  end
      3'd2: begin t1_nxt = vx;  t2_nxt = -vy; end
      3'd3: begin t1_nxt = vz;  t2_nxt = -vx; end
      3'd4: begin t1_nxt = -vy; t2_nxt = -vz; end
      default: begin t1_nxt = -vx; t2_nxt = vy; end
    endcase
  end

  // T0 with floor at zero.
  always_comb begin
    logic signed [ACC_W+3:0] t0;
    t0 = (ACC_W+4)'(64'sd1 <<< 30) - (ACC_W+4)'(t1_r) - (ACC_W+4)'(t2_r);
    ovm_nxt = t0 < 0;
    half_nxt = ovm_nxt ? '0 : (t0 >>> 1);
  end

  // Phase mix and rounding.
  function automatic logic [DW-1:0] to_duty(input logic signed [ACC_W+4:0] q);
    logic signed [ACC_W+4:0] r;
    begin
      r = (q + (ACC_W+5)'(64'sd1 <<< (29-DUTY_FRAC_BITS))) >>> (30-DUTY_FRAC_BITS);
      if (r > (ACC_W+5)'((64'sd1 <<< DW) - 1)) r = (ACC_W+5)'((64'sd1 <<< DW) - 1);
      return DW'(r);
    end
  endfunction

  always_comb begin
    logic signed [ACC_W+4:0] h, a, b, du, dv, dw;
    h = (ACC_W+5)'(half_r);
    a = (ACC_W+5)'(t1e_r);
    b = (ACC_W+5)'(t2e_r);
    case (sece_r)
      3'd0: begin du = h+a+b; dv = h+b;   dw = h;     end
      3'd1: begin du = h+a;   dv = h+a+b; dw = h;     end
      3'd2: begin du = h;     dv = h+a+b; dw = h+b;   end
      3'd3: begin du = h;     dv = h+a;   dw = h+a+b; end
      3'd4: begin du = h+b;   dv = h;     dw = h+a+b; end
      default: begin du = h+a+b; dv = h; dw = h+a;   end
    endcase
    out_nxt = OW'({ovm_r, sece_r, to_duty(dw), to_duty(dv), to_duty(du)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NV; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= cvld;
      for (int k = 1; k < NV; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= 67'(cx) * $signed({1'b0, INVGAIN_Q30});
      ay_r   <= 67'(cy) * $signed({1'b0, INVGAIN_Q30});
      al_r   <= ACC_W'(ax_r >>> 30);
      be_r   <= ACC_W'(ay_r >>> 30);
      sbp_r  <= 68'(be_r) * $signed({1'b0, ROOT3_Q30});
      al2_r  <= al_r;
      be2_r  <= be_r;
      sec_r  <= sec_nxt;
      t1_r   <= t1_nxt;
      t2_r   <= t2_nxt;
      half_r <= half_nxt;
      t1e_r  <= t1_r;
      t2e_r  <= t2_r;
      sece_r <= sec_r;
      ovm_r  <= ovm_nxt;
      out_r  <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[NV-1];
  assign out_tdata  = out_r;

  // Sector field never reaches six or seven.
  a_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3*DW +: 3] <= 3'd5)) else $error("bad sector");
  // A stalled stage keeps its word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("stall lost word");
  // Overmodulation only with T0 floored means no zero-vector half.
  a_ovm: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && ovm_r) |-> (half_r == '0)) else $error("ovm half");

endmodule
